/* sv/mahd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mahd_pkg;

    localparam logic [10:0] SYNC_PATTERN = 11'h7FF;
    localparam int          DIV_STAGES   = 6;
    localparam int          PIPE_DEPTH   = DIV_STAGES + 2;

    localparam logic [1:0] VER_MPEG1  = 2'd1;
    localparam logic [1:0] VER_MPEG2  = 2'd2;
    localparam logic [1:0] VER_MPEG25 = 2'd3;
    localparam logic [1:0] VER_NONE   = 2'd0;

    localparam logic [1:0] LAYER_1    = 2'd1;
    localparam logic [1:0] LAYER_2    = 2'd2;
    localparam logic [1:0] LAYER_3    = 2'd3;
    localparam logic [1:0] LAYER_NONE = 2'd0;

    localparam logic [1:0] CHMODE_MONO = 2'd3;

    localparam logic [10:0] SPF_L1   = 11'd384;
    localparam logic [10:0] SPF_HALF = 11'd576;
    localparam logic [10:0] SPF_FULL = 11'd1152;

    localparam logic [17:0] SCALE_L1   = 18'd12000;
    localparam logic [17:0] SCALE_HALF = 18'd72000;
    localparam logic [17:0] SCALE_FULL = 18'd144000;

    // rows: MPEG1 L1, MPEG1 L2, MPEG1 L3, MPEG2/2.5 L1, MPEG2/2.5 L2/L3
    localparam logic [8:0] KBPS_TABLE [0:4][0:15] = '{
        '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
          9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
        '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
          9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    };

    // rows: MPEG1, MPEG2, MPEG2.5
    localparam logic [15:0] HZ_TABLE [0:2][0:3] = '{
        '{16'd44100, 16'd48000, 16'd32000, 16'd0},
        '{16'd22050, 16'd24000, 16'd16000, 16'd0},
        '{16'd11025, 16'd12000, 16'd8000,  16'd0}
    };

    typedef struct packed {
        logic        ok;
        logic [1:0]  ver;
        logic [1:0]  layer;
        logic [8:0]  kbps;
        logic [15:0] hz;
        logic [1:0]  chans;
        logic [10:0] spf;
        logic        pad;
        logic        quad;
    } hdr_info_t;

    // rem: partial remainder; bits: dividend bits still to shift in,
    // quotient bits shifted in from the bottom
    typedef struct packed {
        logic [15:0] rem;
        logic [11:0] bits;
    } rdiv_t;

    function automatic logic [1:0] ver_of_code(input logic [1:0] code);
        logic [1:0] v;
        case (code)
            2'b00:   v = VER_MPEG25;
            2'b10:   v = VER_MPEG2;
            2'b11:   v = VER_MPEG1;
            default: v = VER_NONE;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] layer_of_code(input logic [1:0] code);
        logic [1:0] l;
        case (code)
            2'b01:   l = LAYER_3;
            2'b10:   l = LAYER_2;
            2'b11:   l = LAYER_1;
            default: l = LAYER_NONE;
        endcase
        return l;
    endfunction

    function automatic rdiv_t div_step(input rdiv_t d, input logic [15:0] divisor);
        logic [16:0] trial;
        logic [16:0] diff;
        rdiv_t       r;
        trial = {d.rem, d.bits[11]};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor}) begin
            r.rem  = diff[15:0];
            r.bits = {d.bits[10:0], 1'b1};
        end else begin
            r.rem  = trial[15:0];
            r.bits = {d.bits[10:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/mahd_decode.sv */
`timescale 1ns / 1ps
`default_nettype none

module mahd_decode
    import mahd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        load,
    input  wire logic [31:0] header_word,
    output hdr_info_t        info_reg,
    output rdiv_t            div_reg
);

    hdr_info_t   info_next;
    rdiv_t       div_next;
    logic [1:0]  ver;
    logic [1:0]  layer;
    logic [2:0]  row;
    logic [8:0]  kbps;
    logic [15:0] hz;
    logic [10:0] spf;
    logic [17:0] scale;
    logic [25:0] dividend;
    logic        ok;

    always_comb begin
        ver   = ver_of_code(header_word[20:19]);
        layer = layer_of_code(header_word[18:17]);
        if (ver == VER_MPEG1) begin
            row = {1'b0, layer} - 3'd1;
        end else if (layer == LAYER_1) begin
            row = 3'd3;
        end else begin
            row = 3'd4;
        end
        kbps = 9'd0;
        hz   = 16'd0;
        if (ver != VER_NONE && layer != LAYER_NONE) begin
            kbps = KBPS_TABLE[row][header_word[15:12]];
            hz   = HZ_TABLE[ver - 2'd1][header_word[11:10]];
        end
        ok = (header_word[31:21] == SYNC_PATTERN) && (ver != VER_NONE)
            && (layer != LAYER_NONE) && (kbps != 9'd0) && (hz != 16'd0);

        if (layer == LAYER_1) begin
            spf   = SPF_L1;
            scale = SCALE_L1;
        end else if (layer == LAYER_3 && ver != VER_MPEG1) begin
            spf   = SPF_HALF;
            scale = SCALE_HALF;
        end else begin
            spf   = SPF_FULL;
            scale = SCALE_FULL;
        end
        dividend = {8'd0, scale} * {17'd0, kbps};

        info_next = '0;
        div_next  = '0;
        if (ok) begin
            info_next.ok    = 1'b1;
            info_next.ver   = ver;
            info_next.layer = layer;
            info_next.kbps  = kbps;
            info_next.hz    = hz;
            info_next.chans = (header_word[7:6] == CHMODE_MONO) ? 2'd1 : 2'd2;
            info_next.spf   = spf;
            info_next.pad   = header_word[9];
            info_next.quad  = (layer == LAYER_1);
            div_next.rem    = {2'b00, dividend[25:12]};
            div_next.bits   = dividend[11:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            info_reg <= info_next;
            div_reg  <= div_next;
        end
    end

endmodule

`default_nettype wire

/* sv/mahd_div_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module mahd_div_stage
    import mahd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      load,
    input  wire hdr_info_t info_in,
    input  wire rdiv_t     div_in,
    output hdr_info_t      info_reg,
    output rdiv_t          div_reg
);

    rdiv_t mid;
    rdiv_t div_next;

    // two quotient bits per stage
    always_comb begin
        mid      = div_step(div_in, info_in.hz);
        div_next = div_step(mid, info_in.hz);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            info_reg <= info_in;
            div_reg  <= div_next;
        end
    end

endmodule

`default_nettype wire

/* sv/mpeg_audio_header_decoder.sv */
// Accepts one header per cycle while the output is not stalled. The divider by the
// sample rate has six stages, two quotient bits per stage, after one decode and
// multiply stage.
// Empty stages close up while the output is stalled.
// Reset (aresetn low, synchronous) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps
`default_nettype none

module mpeg_audio_header_decoder
    import mahd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // [31:0] header_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] mpeg_version, [3:2] layer_number, [12:4] bitrate_kbps,
    // [28:13] sample_rate_hz, [30:29] channel_count, [41:31] samples_per_frame,
    // [53:42] frame_bytes, [55:54] zero
    output logic [55:0]      m_tdata,
    output logic             m_tuser   // [0] valid_res
);

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] adv;

    hdr_info_t info_pipe [0:DIV_STAGES];
    rdiv_t     div_pipe  [0:DIV_STAGES];

    hdr_info_t   fin;
    logic [11:0] quo;
    logic [11:0] bytes;
    logic [55:0] tdata_reg;
    logic [55:0] tdata_next;
    logic        tuser_reg;
    logic        tuser_next;

    // a stage advances when it is empty or the one after it advances
    always_comb begin
        adv[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || m_tready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        for (int i = 0; i < PIPE_DEPTH; i++) begin
            if (!adv[i]) begin
                valid_next[i] = valid_reg[i];
            end else if (i == 0) begin
                valid_next[i] = s_tvalid;
            end else begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    mahd_decode u_decode (
        .aclk        (aclk),
        .load        (adv[0]),
        .header_word (s_tdata),
        .info_reg    (info_pipe[0]),
        .div_reg     (div_pipe[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        mahd_div_stage u_div (
            .aclk     (aclk),
            .load     (adv[g+1]),
            .info_in  (info_pipe[g]),
            .div_in   (div_pipe[g]),
            .info_reg (info_pipe[g+1]),
            .div_reg  (div_pipe[g+1])
        );
    end

    // add padding, scale Layer I slots to bytes, zero invalid headers
    always_comb begin
        fin = info_pipe[DIV_STAGES];
        quo = div_pipe[DIV_STAGES].bits;
        if (fin.quad) begin
            bytes = 12'({quo[9:0], 2'b00} + {9'd0, fin.pad, 2'b00});
        end else begin
            bytes = quo + {11'd0, fin.pad};
        end
        tdata_next = {2'b00, bytes, fin.spf, fin.chans, fin.hz, fin.kbps,
                      fin.layer, fin.ver};
        tuser_next = fin.ok;
        if (!fin.ok) begin
            tdata_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[PIPE_DEPTH-1]) begin
            tdata_reg <= tdata_next;
            tuser_reg <= tuser_next;
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[PIPE_DEPTH-1];
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

`default_nettype wire

/* bench/tb_mpeg_audio_header_decoder.sv */
`timescale 1ns / 1ps

module tb_mpeg_audio_header_decoder;
    import mahd_pkg::*;

    // header code points, as they appear in the frame header word
    localparam logic [1:0] VCODE_25   = 2'b00;
    localparam logic [1:0] VCODE_RSVD = 2'b01;
    localparam logic [1:0] VCODE_2    = 2'b10;
    localparam logic [1:0] VCODE_1    = 2'b11;

    localparam logic [1:0] LCODE_RSVD = 2'b00;
    localparam logic [1:0] LCODE_3    = 2'b01;
    localparam logic [1:0] LCODE_2    = 2'b10;
    localparam logic [1:0] LCODE_1    = 2'b11;

    localparam logic [3:0] BR_FREE = 4'd0;
    localparam logic [3:0] BR_MIN  = 4'd1;
    localparam logic [3:0] BR_MAX  = 4'd14;
    localparam logic [3:0] BR_BAD  = 4'd15;

    localparam logic [1:0] SR_0    = 2'd0;
    localparam logic [1:0] SR_1    = 2'd1;
    localparam logic [1:0] SR_2    = 2'd2;
    localparam logic [1:0] SR_RSVD = 2'd3;

    localparam logic [1:0] CHMODE_STEREO = 2'd0;
    localparam logic [1:0] CHMODE_JOINT  = 2'd1;
    localparam logic [1:0] CHMODE_DUAL   = 2'd2;

    localparam int NUM_RANDOM = 1080;
    localparam int DRAIN_AT   = 450;
    localparam int STALL_AT   = 300;
    localparam int STALL_LEN  = 60;
    localparam int BURST_LO   = 600;
    localparam int BURST_HI   = 800;
    localparam int IDLE_PCT   = 38;

    localparam int unsigned KBPS_ROWS [5][16] = '{
        '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
        '{0, 32, 48, 56,  64,  80,  96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
        '{0, 32, 40, 48,  56,  64,  80,  96, 112, 128, 160, 192, 224, 256, 320, 0},
        '{0, 32, 48, 56,  64,  80,  96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
        '{0,  8, 16, 24,  32,  40,  48,  56,  64,  80,  96, 112, 128, 144, 160, 0}
    };

    localparam int unsigned HZ_ROWS [3][4] = '{
        '{44100, 48000, 32000, 0},
        '{22050, 24000, 16000, 0},
        '{11025, 12000,  8000, 0}
    };

    typedef struct packed {
        logic        valid;
        logic [1:0]  ver;
        logic [1:0]  layer;
        logic [8:0]  kbps;
        logic [15:0] hz;
        logic [1:0]  chans;
        logic [10:0] spf;
        logic [11:0] bytes;
    } hdr_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [55:0] m_tdata;
    logic        m_tuser;

    logic [31:0] header_q [$];
    hdr_result_t decoded_q [$];
    int          headers_sent = 0;
    int          results_seen = 0;
    int          error_count  = 0;
    int          stall_cnt    = 0;
    bit          stall_done   = 1'b0;
    hdr_result_t got;
    hdr_result_t want;

    mpeg_audio_header_decoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic logic [31:0] form_header(input logic [10:0] sync, input logic [1:0] vc,
                                                input logic [1:0] lc, input logic [3:0] br,
                                                input logic [1:0] sr, input logic pad,
                                                input logic [1:0] mode, input logic [31:0] fill);
        return {sync, vc, lc, fill[16], br, sr, pad, fill[8], mode, fill[5:0]};
    endfunction

    function automatic hdr_result_t decode_header(input logic [31:0] hw);
        hdr_result_t res;
        logic [1:0]  ver;
        logic [1:0]  layer;
        int unsigned row;
        int unsigned kbps;
        int unsigned hz;
        int unsigned spf;
        int unsigned scale;
        int unsigned body;
        int unsigned bytes;
        res = '0;
        if (hw[31:21] != SYNC_PATTERN)
            return res;
        case (hw[20:19])
            VCODE_1:  ver = VER_MPEG1;
            VCODE_2:  ver = VER_MPEG2;
            VCODE_25: ver = VER_MPEG25;
            default:  ver = VER_NONE;
        endcase
        if (ver == VER_NONE)
            return res;
        case (hw[18:17])
            LCODE_1: layer = LAYER_1;
            LCODE_2: layer = LAYER_2;
            LCODE_3: layer = LAYER_3;
            default: layer = LAYER_NONE;
        endcase
        if (layer == LAYER_NONE)
            return res;
        if (ver == VER_MPEG1)
            row = layer - 1;
        else
            row = (layer == LAYER_1) ? 3 : 4;
        kbps = KBPS_ROWS[row][hw[15:12]];
        if (kbps == 0)
            return res;
        hz = HZ_ROWS[ver - 1][hw[11:10]];
        if (hz == 0)
            return res;
        if (layer == LAYER_1)
            spf = 384;
        else if (layer == LAYER_2 || ver == VER_MPEG1)
            spf = 1152;
        else
            spf = 576;
        scale = (spf == 384) ? 12 : (spf == 576) ? 72 : 144;
        body  = (scale * kbps * 1000) / hz;
        bytes = (spf == 384) ? (body + hw[9]) * 4 : body + hw[9];
        res.valid = 1'b1;
        res.ver   = ver;
        res.layer = layer;
        res.kbps  = kbps[8:0];
        res.hz    = hz[15:0];
        res.chans = (hw[7:6] == CHMODE_MONO) ? 2'd1 : 2'd2;
        res.spf   = spf[10:0];
        res.bytes = bytes[11:0];
        return res;
    endfunction

    function automatic logic [31:0] random_header();
        logic [1:0]  vc;
        logic [10:0] sync;
        logic [31:0] hw;
        int          pick;
        pick = $urandom_range(99);
        if (pick >= 88)
            return $urandom;
        case ($urandom_range(2))
            0:       vc = VCODE_25;
            1:       vc = VCODE_2;
            default: vc = VCODE_1;
        endcase
        hw = form_header(SYNC_PATTERN, vc, 2'($urandom_range(1, 3)),
                         4'($urandom_range(BR_MIN, BR_MAX)), 2'($urandom_range(SR_0, SR_2)),
                         1'($urandom), 2'($urandom), $urandom);
        if (pick >= 75) begin
            // break one field of an otherwise legal header
            case ($urandom_range(4))
                0: begin
                    sync = SYNC_PATTERN ^ (11'd1 << $urandom_range(10));
                    hw[31:21] = sync;
                end
                1: hw[20:19] = VCODE_RSVD;
                2: hw[18:17] = LCODE_RSVD;
                3: hw[15:12] = $urandom_range(1) ? BR_BAD : BR_FREE;
                default: hw[11:10] = SR_RSVD;
            endcase
        end
        return hw;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < 40)
            $display("mismatch at result %0d: %s", results_seen, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] g, input logic [15:0] w);
        if (g !== w)
            report_mismatch($sformatf("%s got %0d want %0d", name, g, w));
    endtask

    // driver: offer pending headers, record the decode of every accepted request
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                decoded_q.push_back(decode_header(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (header_q.size() != 0
                    && !(headers_sent == DRAIN_AT && decoded_q.size() != 0)
                    && ((headers_sent >= BURST_LO && headers_sent < BURST_HI)
                        || $urandom_range(99) >= IDLE_PCT)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= header_q.pop_front();
                    headers_sent++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver readiness, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_cnt != 0) begin
            m_tready  <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end else if (!stall_done && results_seen >= STALL_AT) begin
            stall_done <= 1'b1;
            stall_cnt  <= STALL_LEN;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= (results_seen >= BURST_LO && results_seen < BURST_HI)
                        || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // monitor: compare each result with the oldest pending decode
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.valid = m_tuser;
            got.ver   = m_tdata[1:0];
            got.layer = m_tdata[3:2];
            got.kbps  = m_tdata[12:4];
            got.hz    = m_tdata[28:13];
            got.chans = m_tdata[30:29];
            got.spf   = m_tdata[41:31];
            got.bytes = m_tdata[53:42];
            if (decoded_q.size() == 0) begin
                report_mismatch("result without a pending request");
            end else begin
                want = decoded_q.pop_front();
                check_field("valid_res", 16'(got.valid), 16'(want.valid));
                check_field("mpeg_version", 16'(got.ver), 16'(want.ver));
                check_field("layer_number", 16'(got.layer), 16'(want.layer));
                check_field("bitrate_kbps", 16'(got.kbps), 16'(want.kbps));
                check_field("sample_rate_hz", got.hz, want.hz);
                check_field("channel_count", 16'(got.chans), 16'(want.chans));
                check_field("samples_per_frame", 16'(got.spf), 16'(want.spf));
                check_field("frame_bytes", 16'(got.bytes), 16'(want.bytes));
            end
            results_seen++;
        end
    end

    initial begin
        header_q.push_back(32'h0000_0000);
        header_q.push_back(32'hFFFF_FFFF);
        header_q.push_back(form_header(11'h7FE, VCODE_1, LCODE_3, 4'd9, SR_0, 1'b0,
                                       CHMODE_STEREO, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_RSVD, LCODE_3, 4'd9, SR_0, 1'b0,
                                       CHMODE_STEREO, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_1, LCODE_RSVD, 4'd9, SR_0, 1'b0,
                                       CHMODE_STEREO, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_1, LCODE_3, BR_FREE, SR_0, 1'b0,
                                       CHMODE_STEREO, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_2, LCODE_2, BR_BAD, SR_0, 1'b0,
                                       CHMODE_STEREO, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_25, LCODE_1, 4'd5, SR_RSVD, 1'b0,
                                       CHMODE_STEREO, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_1, LCODE_1, BR_MAX, SR_2, 1'b1,
                                       CHMODE_STEREO, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_1, LCODE_1, BR_MIN, SR_0, 1'b0,
                                       CHMODE_STEREO, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_1, LCODE_2, BR_MAX, SR_1, 1'b0,
                                       CHMODE_MONO, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_1, LCODE_3, BR_MIN, SR_0, 1'b1,
                                       CHMODE_JOINT, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_2, LCODE_1, BR_MAX, SR_2, 1'b1,
                                       CHMODE_DUAL, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_2, LCODE_2, BR_MAX, SR_2, 1'b1,
                                       CHMODE_STEREO, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_2, LCODE_3, BR_MIN, SR_0, 1'b0,
                                       CHMODE_MONO, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_25, LCODE_1, BR_MIN, SR_1, 1'b0,
                                       CHMODE_STEREO, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_25, LCODE_2, BR_MAX, SR_2, 1'b1,
                                       CHMODE_STEREO, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_25, LCODE_3, BR_MAX, SR_2, 1'b1,
                                       CHMODE_MONO, 32'h0));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_1, LCODE_3, 4'd9, SR_0, 1'b1,
                                       CHMODE_MONO, 32'hFFFF_FFFF));
        header_q.push_back(form_header(SYNC_PATTERN, VCODE_1, LCODE_3, 4'd9, SR_0, 1'b0,
                                       CHMODE_STEREO, 32'h0));
        for (int i = 0; i < NUM_RANDOM; i++)
            header_q.push_back(random_header());

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (header_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (decoded_q.size() != 0)
            @(posedge aclk);
        repeat (PIPE_DEPTH * 4) @(posedge aclk);
        if (decoded_q.size() != 0)
            report_mismatch("requests left without a result");

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
sv/mahd_pkg.sv
sv/mahd_decode.sv
sv/mahd_div_stage.sv
sv/mpeg_audio_header_decoder.sv
bench/tb_mpeg_audio_header_decoder.sv
